// ===== sv/plim_pkg.sv =====
// Shared constants, types and the key mask helper function of the per-key connection limiter.
`timescale 1ns / 1ps
package plim_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int KEY_BYTES     = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = 64;
    localparam int LEN_W         = 4;
    localparam int CNT_W         = 16;
    localparam int CODE_W        = 10;
    localparam int MEM_W         = KEY_W + LEN_W + CNT_W;

    localparam logic [CNT_W-1:0]  LIMIT_RESET = 16'd1;
    localparam logic [CODE_W-1:0] CODE_RESET  = 10'd503;

    typedef enum logic [1:0] {
        CFG_LIMIT  = 2'd0,
        CFG_DRY    = 2'd1,
        CFG_CODE   = 2'd2,
        CFG_UNUSED = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OUT_PASSED       = 3'd0,
        OUT_REJECTED     = 3'd1,
        OUT_REJECTED_DRY = 3'd2,
        OUT_SKIPPED      = 3'd3,
        OUT_RELEASED     = 3'd4,
        OUT_UNKNOWN      = 3'd5
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [MEM_W-1:0] wdata;
    } t_ram_req;

    typedef struct packed {
        logic [CNT_W-1:0]  limit;
        logic              dry_run;
        logic [CODE_W-1:0] reject_code;
    } t_cfg;

    function automatic logic [KEY_W-1:0] bytes_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < int'(len)) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/plim_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module plim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/plim_ctrl.sv =====
// Lookup sequencer: scans the slot memory, updates at most one entry and registers the result.
`timescale 1ns / 1ps
module plim_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  plim_pkg::t_cfg               i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_opcode,
    input  logic [plim_pkg::KEY_W-1:0]   i_key_value,
    input  logic [plim_pkg::LEN_W-1:0]   i_key_length,
    input  logic                         i_already_checked,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_outcome,
    output logic                         o_table_exhausted,
    output logic [plim_pkg::CNT_W-1:0]   o_connection_count,
    output logic [plim_pkg::CODE_W-1:0]  o_response_code,
    output plim_pkg::t_ram_req           o_ram_req,
    input  logic [plim_pkg::MEM_W-1:0]   i_ram_rdata
);
    localparam logic [plim_pkg::IDX_W-1:0] LAST_IDX = plim_pkg::IDX_W'(plim_pkg::TABLE_ENTRIES - 1);

    plim_pkg::t_state r_state, n_state;

    logic [plim_pkg::TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic                         r_op;
    logic [plim_pkg::KEY_W-1:0]   r_key;
    logic [plim_pkg::LEN_W-1:0]   r_len;
    logic                         r_direct, n_direct;
    logic [plim_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                         r_issue, n_issue;
    logic                         r_chk, n_chk;
    logic [plim_pkg::IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic                         r_found, n_found;
    logic [plim_pkg::IDX_W-1:0]   r_found_idx, n_found_idx;
    logic [plim_pkg::CNT_W-1:0]   r_found_cnt, n_found_cnt;
    logic                         r_free, n_free;
    logic [plim_pkg::IDX_W-1:0]   r_free_idx, n_free_idx;

    logic                         r_out_valid, n_out_valid;
    logic [2:0]                   r_outcome, n_outcome;
    logic                         r_exh, n_exh;
    logic [plim_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [plim_pkg::CODE_W-1:0]  r_code, n_code;

    logic accept, usable, direct_in, out_free, hit, scan_end, load;
    logic [plim_pkg::KEY_W-1:0] mem_key;
    logic [plim_pkg::LEN_W-1:0] mem_len;
    logic [plim_pkg::CNT_W-1:0] mem_cnt;
    logic [2:0] rej_outcome;
    logic [plim_pkg::CODE_W-1:0] rej_code;
    plim_pkg::t_ram_req ram_req;

    assign accept    = i_in_valid && (r_state == plim_pkg::ST_IDLE);
    assign usable    = (i_key_length != '0) &&
                       (i_key_length <= plim_pkg::LEN_W'(plim_pkg::KEY_BYTES));
    assign direct_in = !usable || (!i_opcode && i_already_checked);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign load      = (r_state == plim_pkg::ST_UPDATE) && out_free;

    assign mem_key = i_ram_rdata[plim_pkg::MEM_W-1 -: plim_pkg::KEY_W];
    assign mem_len = i_ram_rdata[plim_pkg::CNT_W +: plim_pkg::LEN_W];
    assign mem_cnt = i_ram_rdata[plim_pkg::CNT_W-1:0];

    assign hit      = r_chk && r_valid[r_chk_idx] && (mem_len == r_len) && (mem_key == r_key);
    assign scan_end = hit || (r_chk && (r_chk_idx == LAST_IDX));

    assign rej_outcome = i_cfg.dry_run ? plim_pkg::OUT_REJECTED_DRY : plim_pkg::OUT_REJECTED;
    assign rej_code    = i_cfg.dry_run ? '0 : i_cfg.reject_code;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            plim_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = direct_in ? plim_pkg::ST_UPDATE : plim_pkg::ST_SCAN;
                end
            end
            plim_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = plim_pkg::ST_UPDATE;
                end
            end
            plim_pkg::ST_UPDATE: begin
                if (out_free) begin
                    n_state = plim_pkg::ST_IDLE;
                end
            end
            default: n_state = plim_pkg::ST_IDLE;
        endcase
    end

    // Scan bookkeeping. Read data arrives in the cycle after its address is issued.
    always_comb begin
        n_direct    = r_direct;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_chk       = 1'b0;
        n_chk_idx   = r_idx;
        n_found     = r_found;
        n_found_idx = r_found_idx;
        n_found_cnt = r_found_cnt;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        if (accept) begin
            n_direct = direct_in;
            n_idx    = '0;
            n_issue  = 1'b1;
            n_found  = 1'b0;
            n_free   = 1'b0;
        end else if (r_state == plim_pkg::ST_SCAN) begin
            n_chk = r_issue && !scan_end;
            if (r_idx == LAST_IDX) begin
                n_issue = 1'b0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
            if (hit) begin
                n_found     = 1'b1;
                n_found_idx = r_chk_idx;
                n_found_cnt = mem_cnt;
            end
            if (r_chk && !r_valid[r_chk_idx] && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_chk_idx;
            end
        end
    end

    // Outputs of the update step: result, table write and valid bits.
    always_comb begin
        n_valid     = r_valid;
        n_out_valid = r_out_valid && i_out_stall;
        n_outcome   = r_outcome;
        n_exh       = r_exh;
        n_cnt       = r_cnt;
        n_code      = r_code;
        ram_req.we    = 1'b0;
        ram_req.addr  = r_idx;
        ram_req.wdata = {r_key, r_len, r_found_cnt};
        if (load) begin
            n_out_valid = 1'b1;
            n_exh       = 1'b0;
            n_code      = '0;
            n_cnt       = '0;
            if (r_direct) begin
                n_outcome = r_op ? plim_pkg::OUT_UNKNOWN : plim_pkg::OUT_SKIPPED;
            end else if (r_op) begin
                if (!r_found) begin
                    n_outcome = plim_pkg::OUT_UNKNOWN;
                end else begin
                    n_outcome = plim_pkg::OUT_RELEASED;
                    n_cnt     = (r_found_cnt != '0) ? r_found_cnt - 1'b1 : r_found_cnt;
                    ram_req.we    = 1'b1;
                    ram_req.addr  = r_found_idx;
                    ram_req.wdata = {r_key, r_len, n_cnt};
                    if (n_cnt == '0) begin
                        n_valid[r_found_idx] = 1'b0;
                    end
                end
            end else if (r_found) begin
                if (r_found_cnt >= i_cfg.limit) begin
                    n_outcome = rej_outcome;
                    n_cnt     = r_found_cnt;
                    n_code    = rej_code;
                end else begin
                    n_outcome = plim_pkg::OUT_PASSED;
                    n_cnt     = r_found_cnt + 1'b1;
                    ram_req.we    = 1'b1;
                    ram_req.addr  = r_found_idx;
                    ram_req.wdata = {r_key, r_len, n_cnt};
                end
            end else if (r_free) begin
                n_outcome = plim_pkg::OUT_PASSED;
                n_cnt     = plim_pkg::CNT_W'(1);
                ram_req.we    = 1'b1;
                ram_req.addr  = r_free_idx;
                ram_req.wdata = {r_key, r_len, n_cnt};
                n_valid[r_free_idx] = 1'b1;
            end else begin
                n_outcome = rej_outcome;
                n_exh     = 1'b1;
                n_code    = rej_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plim_pkg::ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
            r_issue     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_chk       <= n_chk;
            r_issue     <= n_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_opcode;
            r_len <= i_key_length;
            r_key <= i_key_value & plim_pkg::bytes_mask(i_key_length);
        end
        r_direct    <= n_direct;
        r_idx       <= n_idx;
        r_chk_idx   <= n_chk_idx;
        r_found     <= n_found;
        r_found_idx <= n_found_idx;
        r_found_cnt <= n_found_cnt;
        r_free      <= n_free;
        r_free_idx  <= n_free_idx;
        r_outcome   <= n_outcome;
        r_exh       <= n_exh;
        r_cnt       <= n_cnt;
        r_code      <= n_code;
    end

    assign o_in_stall         = (r_state != plim_pkg::ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_outcome          = r_outcome;
    assign o_table_exhausted  = r_exh;
    assign o_connection_count = r_cnt;
    assign o_response_code    = r_code;
    assign o_ram_req          = ram_req;
endmodule

// ===== sv/per_key_connection_limiter.sv =====
// Per-key concurrent connection limiter: configuration registers and slot memory.
// Each transfer is either an acquire or a release of one connection under a key of up to
// eight bytes. Keys live in a single-port slot memory with a registered read; a lookup
// reads the slots one per cycle, from slot 0 upwards, stopping at the matching key, and
// notes the lowest free slot on the way. Skipped acquires and any item with an empty or
// too-long key go straight to the update step; any other item first scans the slots, up
// to all TABLE_ENTRIES of them when there is no match. A result is held in an output
// register until it is taken, and the next item is accepted once the update is done.
`timescale 1ns / 1ps
module per_key_connection_limiter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [plim_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic [plim_pkg::KEY_W-1:0]    i_key_value,
    input  logic [plim_pkg::LEN_W-1:0]    i_key_length,
    input  logic                          i_already_checked,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_outcome,
    output logic                          o_table_exhausted,
    output logic [plim_pkg::CNT_W-1:0]    o_connection_count,
    output logic [plim_pkg::CODE_W-1:0]   o_response_code
);
    plim_pkg::t_cfg r_cfg;
    plim_pkg::t_ram_req ram_req;
    logic [plim_pkg::MEM_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit       <= plim_pkg::LIMIT_RESET;
            r_cfg.dry_run     <= 1'b0;
            r_cfg.reject_code <= plim_pkg::CODE_RESET;
        end else if (i_cfg_we) begin
            case (plim_pkg::t_cfg_idx'(i_cfg_idx))
                plim_pkg::CFG_LIMIT: r_cfg.limit       <= i_cfg_data;
                plim_pkg::CFG_DRY:   r_cfg.dry_run     <= i_cfg_data[0];
                plim_pkg::CFG_CODE:  r_cfg.reject_code <= i_cfg_data[plim_pkg::CODE_W-1:0];
                default: ;
            endcase
        end
    end

    plim_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_key_value        (i_key_value),
        .i_key_length       (i_key_length),
        .i_already_checked  (i_already_checked),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_outcome          (o_outcome),
        .o_table_exhausted  (o_table_exhausted),
        .o_connection_count (o_connection_count),
        .o_response_code    (o_response_code),
        .o_ram_req          (ram_req),
        .i_ram_rdata        (ram_rdata)
    );

    plim_ram #(
        .WIDTH (plim_pkg::MEM_W),
        .DEPTH (plim_pkg::TABLE_ENTRIES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (ram_rdata)
    );
endmodule
